// ===== sv/masked_delta_average_update_macros.svh =====
// ----------------------------------------------------------------------------
// masked_delta_average_update concurrent assertion macros on clk
// MDAU_ASSERT is disabled while rst_n is low; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef MASKED_DELTA_AVERAGE_UPDATE_MACROS_SVH
`define MASKED_DELTA_AVERAGE_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF
`define MDAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MDAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MDAU_ASSERT(label, prop, msg)
`define MDAU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== sv/mdau_pkg.sv =====
// ----------------------------------------------------------------------------
// mdau_pkg
// Shared types and constants of the masked delta average update block.
// ----------------------------------------------------------------------------
package mdau_pkg;

    localparam int SLOTS          = 4;
    localparam int PEERS_DEFAULT  = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int LANE_W         = 16;

    localparam logic [LANE_W-1:0] ZERO_SEED_SUB = 16'hACE1;
    localparam logic [LANE_W-1:0] TAPS_RESET    = 16'hB400;

    localparam logic [CFG_INDEX_W-1:0] REG_PEER_MASK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_0    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_1    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_2    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_3    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TAPS      = 3'd5;

    typedef struct packed {
        logic              first_weight;
        logic signed [7:0] base_weight;
        logic [7:0]        delta_0;
        logic [7:0]        delta_1;
        logic [7:0]        delta_2;
        logic [7:0]        delta_3;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] new_weight;
        logic              no_update;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic unmask;
        logic finish;
    } mdau_cmd_t;

    typedef struct packed {
        logic out_busy;
    } mdau_status_t;

endpackage

// ===== sv/mdau_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdau_ctrl
// Sequencer: accept, unmask and sum, then divide and load the result register.
// ----------------------------------------------------------------------------
`include "masked_delta_average_update_macros.svh"

module mdau_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mdau_pkg::mdau_status_t status,
    output mdau_pkg::mdau_cmd_t   cmd
);
    import mdau_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNMASK,
        S_DIV
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        cmd.load_item = (state_reg == S_IDLE) && item_valid;
        cmd.unmask    = (state_reg == S_UNMASK);
        cmd.finish    = (state_reg == S_DIV) && !status.out_busy;
    end

    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_UNMASK;
                    stall_next = 1'b1;
                end
            end
            S_UNMASK:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                    stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign item_stall = stall_reg;

    `MDAU_ASSERT(a_cmd_onehot, $onehot0({cmd.load_item, cmd.unmask, cmd.finish}), "commands overlap")
    `MDAU_ASSERT(a_unmask_after_load, cmd.unmask |-> $past(cmd.load_item), "unmask without load")
    `MDAU_ASSERT(a_stall_while_busy, cmd.load_item |=> item_stall, "no stall after transfer")

endmodule

// ===== sv/mdau_dp.sv =====
// ----------------------------------------------------------------------------
// mdau_dp
// Config registers, LFSR lanes, unmask and sum, divide by peer count, clamp.
// ----------------------------------------------------------------------------
`include "masked_delta_average_update_macros.svh"

module mdau_dp #(
    parameter int PEERS = mdau_pkg::PEERS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [mdau_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mdau_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mdau_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mdau_pkg::out_item_t                 result,
    input  mdau_pkg::mdau_cmd_t                 cmd,
    output mdau_pkg::mdau_status_t              status
);
    import mdau_pkg::*;

    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    function automatic logic [LANE_W+7:0] lfsr_byte(
        input logic [LANE_W-1:0] lane,
        input logic [LANE_W-1:0] taps
    );
        logic [LANE_W-1:0] r;
        logic [7:0]        ks;
        r  = lane;
        ks = '0;
        for (int i = 0; i < 8; i++)
        begin
            ks[i] = r[0];
            r     = r[0] ? ((r >> 1) ^ taps) : (r >> 1);
        end
        return {r, ks};
    endfunction

    logic [SLOTS-1:0]  peer_mask_reg;
    logic [LANE_W-1:0] seed_reg [SLOTS];
    logic [LANE_W-1:0] taps_reg;
    logic [LANE_W-1:0] lane_reg [SLOTS];
    logic [LANE_W-1:0] lane_step [SLOTS];
    logic [7:0]        ks_byte [SLOTS];
    logic [7:0]        delta [SLOTS];
    logic [SLOTS-1:0]  slot_ok;
    logic [SLOTS-1:0]  enable;

    in_item_t          item_reg;
    logic [9:0]        mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [2:0]        count_reg, count_next;
    logic signed [9:0] sum;

    logic [19:0]        prod3;
    logic [9:0]         quot;
    logic signed [10:0] quot_s;
    logic signed [10:0] upd;
    out_item_t          result_reg, result_next;
    logic               valid_reg;

    for (genvar p = 0; p < SLOTS; p++)
    begin : g_slot
        assign slot_ok[p]                = (p < PEERS);
        assign {lane_step[p], ks_byte[p]} = lfsr_byte(lane_reg[p], taps_reg);
    end

    assign enable   = peer_mask_reg & slot_ok;
    assign delta[0] = item_reg.delta_0;
    assign delta[1] = item_reg.delta_1;
    assign delta[2] = item_reg.delta_2;
    assign delta[3] = item_reg.delta_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_mask_reg <= '0;
            taps_reg      <= TAPS_RESET;
            for (int p = 0; p < SLOTS; p++)
                seed_reg[p] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PEER_MASK: peer_mask_reg <= cfg_data[SLOTS-1:0];
                REG_SEED_0:    seed_reg[0]   <= cfg_data;
                REG_SEED_1:    seed_reg[1]   <= cfg_data;
                REG_SEED_2:    seed_reg[2]   <= cfg_data;
                REG_SEED_3:    seed_reg[3]   <= cfg_data;
                REG_TAPS:      taps_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < SLOTS; p++)
                lane_reg[p] <= ZERO_SEED_SUB;
        end
        else
        begin
            for (int p = 0; p < SLOTS; p++)
            begin
                if (cmd.load_item && item.first_weight)
                    lane_reg[p] <= (seed_reg[p] != '0) ? seed_reg[p] : ZERO_SEED_SUB;
                else if (cmd.unmask && enable[p])
                    lane_reg[p] <= lane_step[p];
            end
        end
    end

    always_comb
    begin
        logic [7:0] d;
        sum        = '0;
        count_next = '0;
        for (int p = 0; p < SLOTS; p++)
        begin
            d = delta[p] ^ ks_byte[p];
            if (enable[p])
            begin
                sum        = sum + $signed({{2{d[7]}}, d});
                count_next = count_next + 3'd1;
            end
        end
        neg_next = sum[9];
        mag_next = sum[9] ? 10'(-sum) : 10'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;
        if (cmd.unmask)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            count_reg <= count_next;
        end
    end

    assign prod3 = mag_reg * DIV3_MUL;

    always_comb
    begin
        case (count_reg)
            3'd1:    quot = mag_reg;
            3'd2:    quot = mag_reg >> 1;
            3'd3:    quot = {1'b0, prod3[19:DIV3_SHIFT]};
            3'd4:    quot = mag_reg >> 2;
            default: quot = '0;
        endcase
        quot_s = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        upd    = $signed({{3{item_reg.base_weight[7]}}, item_reg.base_weight}) + quot_s;
        if (count_reg == '0)
        begin
            result_next.new_weight = item_reg.base_weight;
            result_next.no_update  = 1'b1;
        end
        else
        begin
            result_next.no_update = 1'b0;
            if (upd > 11'sd127)
                result_next.new_weight = 8'sd127;
            else if (upd < -11'sd128)
                result_next.new_weight = -8'sd128;
            else
                result_next.new_weight = upd[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.finish)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    assign result_valid    = valid_reg;
    assign result          = result_reg;
    assign status.out_busy = valid_reg && result_stall;

    `MDAU_ASSERT(a_valid_from_finish, $rose(result_valid) |-> $past(cmd.finish), "result without finish")
    `MDAU_ASSERT(a_finish_shows, cmd.finish |=> result_valid, "finish not shown")
    `MDAU_ASSERT(a_no_peer_flag, (cmd.finish && count_reg == '0) |=> result.no_update, "no_update missing")

endmodule

// ===== sv/masked_delta_average_update.sv =====
// ----------------------------------------------------------------------------
// masked_delta_average_update
// Federated average of INT8 weights with per-peer LFSR unmasking of deltas.
// ----------------------------------------------------------------------------
// An item passes the transfer in idle, an unmask state in which each enabled
// LFSR lane steps eight times and the unmasked deltas are summed, and a divide
// state that divides by the peer count and clamps into the result register.
// The result register frees the input side, so the next item is taken while a
// result still waits; a result stalled past the divide state holds the
// sequencer there. No new item is taken until the last has left the divide state.
// Config writes are always ready and must land only while the block is idle.
module masked_delta_average_update #(
    parameter int PEERS = mdau_pkg::PEERS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mdau_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mdau_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mdau_pkg::in_item_t               item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mdau_pkg::out_item_t              result
);
    import mdau_pkg::*;

    mdau_cmd_t    cmd;
    mdau_status_t status;

    assign cfg_ready = 1'b1;

    mdau_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mdau_dp #(
        .PEERS (PEERS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: masked_delta_average_update testbench
// Directed and random weight streams under several register settings; each
// transfer is predicted (LFSR unmasking, peer average, INT8 clamp) and results
// are compared field by field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import mdau_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 48;
    localparam int W_MAX         = 127;
    localparam int W_MIN         = -128;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    class avg_weight_board;
        logic [3:0]  peer_mask;
        logic [15:0] seed [SLOTS];
        logic [15:0] taps;
        logic [15:0] lane [SLOTS];
        out_item_t   expected_weights [$];
        int          mismatches;
        int          results_seen;

        function new();
            peer_mask = '0;
            taps = TAPS_RESET;
            foreach (seed[p])
            begin
                seed[p] = '0;
                lane[p] = ZERO_SEED_SUB;
            end
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
            case (index)
                REG_PEER_MASK: peer_mask = data[3:0];
                REG_SEED_0:    seed[0] = data;
                REG_SEED_1:    seed[1] = data;
                REG_SEED_2:    seed[2] = data;
                REG_SEED_3:    seed[3] = data;
                REG_TAPS:      taps = data;
                default:       ;
            endcase
        endfunction

        function logic [15:0] seeded(int p);
            return (seed[p] == '0) ? ZERO_SEED_SUB : seed[p];
        endfunction

        // eight Galois steps: {keystream byte, next lane}
        function logic [23:0] advance(logic [15:0] r);
            logic [7:0] k;
            for (int i = 0; i < 8; i++)
            begin
                k[i] = r[0];
                r = r[0] ? ((r >> 1) ^ taps) : (r >> 1);
            end
            return {k, r};
        endfunction

        function logic [7:0] key_byte(int p, logic reload);
            logic [23:0] s;
            s = advance(reload ? seeded(p) : lane[p]);
            return s[23:16];
        endfunction

        function void accept_item(in_item_t x);
            logic [7:0]        raw [SLOTS];
            logic [23:0]       s;
            logic signed [7:0] d;
            logic signed [7:0] base;
            int                sum;
            int                n;
            int                upd;
            out_item_t         e;
            raw = '{x.delta_0, x.delta_1, x.delta_2, x.delta_3};
            base = x.base_weight;
            sum = 0;
            n = 0;
            if (x.first_weight)
                foreach (lane[p])
                    lane[p] = seeded(p);
            for (int p = 0; p < SLOTS; p++)
            begin
                if (peer_mask[p])
                begin
                    s = advance(lane[p]);
                    lane[p] = s[15:0];
                    d = raw[p] ^ s[23:16];
                    sum += d;
                    n++;
                end
            end
            if (n == 0)
            begin
                e.new_weight = base;
                e.no_update = 1'b1;
            end
            else
            begin
                upd = base + sum / n;
                if (upd > W_MAX)
                    upd = W_MAX;
                else if (upd < W_MIN)
                    upd = W_MIN;
                e.new_weight = upd[7:0];
                e.no_update = 1'b0;
            end
            expected_weights.push_back(e);
        endfunction

        function void note(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_weight(out_item_t got);
            out_item_t want;
            results_seen++;
            if (expected_weights.size() == 0)
            begin
                note($sformatf("result %0d: no transfer outstanding, got new_weight %0d",
                               results_seen, $signed(got.new_weight)));
                return;
            end
            want = expected_weights.pop_front();
            if (got.new_weight !== want.new_weight)
                note($sformatf("result %0d: new_weight expected %0d, got %0d", results_seen,
                               $signed(want.new_weight), $signed(got.new_weight)));
            if (got.no_update !== want.no_update)
                note($sformatf("result %0d: no_update expected %0b, got %0b", results_seen,
                               want.no_update, got.no_update));
        endfunction

        function int pending();
            return expected_weights.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    in_item_t               item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    out_item_t              result;

    avg_weight_board board = new();
    bit                     steady = 1'b0;
    bit                     hold_req = 1'b0;
    int                     quiet_cycles = 0;

    masked_delta_average_update DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // choose masked bytes so the unmasked deltas come out as the given values
    function automatic in_item_t craft(logic fw, byte base, byte t0, byte t1, byte t2,
                                       byte t3);
        in_item_t x;
        x.first_weight = fw;
        x.base_weight = base;
        x.delta_0 = t0 ^ board.key_byte(0, fw);
        x.delta_1 = t1 ^ board.key_byte(1, fw);
        x.delta_2 = t2 ^ board.key_byte(2, fw);
        x.delta_3 = t3 ^ board.key_byte(3, fw);
        return x;
    endfunction

    function automatic in_item_t random_item(logic fw);
        in_item_t x;
        byte      t;
        x.first_weight = fw;
        x.base_weight = 8'($urandom);
        x.delta_0 = 8'($urandom);
        x.delta_1 = 8'($urandom);
        x.delta_2 = 8'($urandom);
        x.delta_3 = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            t = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
            if ($urandom_range(0, 1))
                x.base_weight = t;
            x = craft(fw, x.base_weight, t, t, t, t);
        end
        return x;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(index, data);
    endtask

    task automatic set_config(logic [3:0] mask, logic [15:0] s0, logic [15:0] s1,
                              logic [15:0] s2, logic [15:0] s3, logic [15:0] taps);
        write_reg(REG_PEER_MASK, {12'($urandom), mask});
        write_reg(REG_SEED_0, s0);
        write_reg(REG_SEED_1, s1);
        write_reg(REG_SEED_2, s2);
        write_reg(REG_SEED_3, s3);
        if ($urandom_range(0, 1))
            write_reg(REG_SPARE_6, 16'($urandom));
        write_reg(REG_TAPS, taps);
        if ($urandom_range(0, 1))
            write_reg(REG_SPARE_7, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(in_item_t x);
        int g;
        item_valid <= 1'b1;
        item <= x;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.accept_item(x);
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic finish_phase();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat (gap_len() + 1) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                board.check_weight(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("masked_delta_average_update: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        logic fw;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no peer enabled, base passes through
        send_item('{1'b1, 8'sh7f, 8'hff, 8'hff, 8'hff, 8'hff});
        send_item('{1'b0, 8'sh80, 8'h00, 8'h00, 8'h00, 8'h00});
        finish_phase();

        set_config(4'hf, '0, '0, '0, '0, TAPS_RESET);
        send_item(craft(1'b1, 127, 127, 127, 127, 127));
        send_item(craft(1'b0, -128, -128, -128, -128, -128));
        send_item(craft(1'b0, 0, -1, -1, -1, -4));
        send_item(craft(1'b0, 0, 3, 2, 2, 0));
        send_item('{1'b0, 8'sh55, 8'h00, 8'h00, 8'h00, 8'h00});
        send_item('{1'b1, 8'shaa, 8'hff, 8'hff, 8'hff, 8'hff});
        send_item('{1'b0, 8'sh7f, 8'h5a, 8'ha5, 8'h0f, 8'hf0});
        finish_phase();

        // zero taps, then a seed rewrite that waits for the next reload
        set_config(4'b0101, 16'hffff, 16'h0001, 16'h8000, 16'h1234, '0);
        send_item(random_item(1'b1));
        send_item(random_item(1'b0));
        send_item(random_item(1'b0));
        finish_phase();
        write_reg(REG_SEED_0, '0);
        cfg_valid <= 1'b0;
        send_item(random_item(1'b0));
        send_item(random_item(1'b0));
        send_item(random_item(1'b1));
        finish_phase();

        set_config(4'b1000, ZERO_SEED_SUB, pick_word(), pick_word(), 16'hbeef, '1);
        send_item(craft(1'b1, -100, 0, 0, 0, -128));
        send_item(random_item(1'b0));
        send_item(random_item(1'b0));
        finish_phase();

        set_config(4'b0111, pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
        send_item(craft(1'b1, 5, -7, 0, 0, 0));
        send_item(craft(1'b0, -5, 7, 0, 0, 0));
        finish_phase();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = (ph == 2 || ph == 5);
            set_config((ph == 0) ? 4'hf : 4'($urandom), pick_word(), pick_word(),
                       pick_word(), pick_word(),
                       ($urandom_range(0, 3) == 0) ? TAPS_RESET : pick_word());
            hold_req = (ph == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                fw = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
                send_item(random_item(fw));
            end
            finish_phase();
            steady = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("masked_delta_average_update: match");
        else
            $display("masked_delta_average_update: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mdau_pkg.sv
sv/mdau_ctrl.sv
sv/mdau_dp.sv
sv/masked_delta_average_update.sv
verif/tb.sv
